// ===== src/twrpc_pkg.sv =====
package twrpc_pkg;

    // field widths
    localparam int unsigned RAW_W      = 16;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned STEP_W     = 16;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned PWR_W      = 15;
    localparam int unsigned DRV_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // drive datapath: exact error, exact product, Q0.16 drop
    localparam int unsigned FRAC_W = GAIN_W;
    localparam int unsigned ERR_W  = POS_W + 1;
    localparam int unsigned PROD_W = ERR_W + GAIN_W;
    localparam int unsigned QUO_W  = PROD_W - FRAC_W;

    // action codes
    localparam logic ACT_TICK       = 1'b0;
    localparam logic ACT_ADD_TARGET = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOTORS_ENABLED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_STEP_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_STEP_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT      = 3'd4;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd3277;
    localparam logic [PWR_W-1:0]  POWER_LIMIT_RST = 15'd200;

    // what the last stage does with the drive
    localparam logic [1:0] OP_DRIVE = 2'd0;
    localparam logic [1:0] OP_ZERO  = 2'd1;
    localparam logic [1:0] OP_HOLD  = 2'd2;

    typedef logic [RAW_W-1:0]         raw_t;
    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic [STEP_W-1:0]        step_t;
    typedef logic [GAIN_W-1:0]        gain_t;
    typedef logic [PWR_W-1:0]         pwr_t;
    typedef logic signed [DRV_W-1:0]  drv_t;

    typedef struct packed {
        logic load1;    // item enters lane state update
        logic tick;     // item is a control tick
        logic enc_ok;   // encoder read succeeded
        logic enabled;  // motors enabled
        logic load2;    // stage 1 -> stage 2
        logic load3;    // stage 2 -> merge register
    } lane_ctrl_t;

    typedef struct packed {
        drv_t                    drive;
        logic signed [RAW_W-1:0] delta;
        pos_t                    odo;
    } lane_result_t;

endpackage

// ===== src/twrpc_if.sv =====
interface twrpc_cmd_if;
    import twrpc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  action;
    raw_t                  left_encoder;
    raw_t                  right_encoder;
    logic                  encoders_valid;
    pos_t                  left_target_move;
    pos_t                  right_target_move;

    modport source (
        output valid, action, left_encoder, right_encoder, encoders_valid,
               left_target_move, right_target_move,
        input  ready
    );
    modport sink (
        input  valid, action, left_encoder, right_encoder, encoders_valid,
               left_target_move, right_target_move,
        output ready
    );
endinterface

interface twrpc_result_if;
    import twrpc_pkg::*;

    logic                    valid;
    logic                    ready;
    drv_t                    left_drive;
    drv_t                    right_drive;
    logic signed [RAW_W-1:0] left_count_delta;
    logic signed [RAW_W-1:0] right_count_delta;
    pos_t                    left_odometer;
    pos_t                    right_odometer;

    modport source (
        output valid, left_drive, right_drive, left_count_delta, right_count_delta,
               left_odometer, right_odometer,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, left_count_delta, right_count_delta,
               left_odometer, right_odometer,
        output ready
    );
endinterface

interface twrpc_cfg_if;
    import twrpc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/twrpc_lane.sv =====
module twrpc_lane (
    input  logic                    clk,
    input  logic                    rst_n,
    input  twrpc_pkg::lane_ctrl_t   ctrl,
    input  twrpc_pkg::raw_t         encoder,
    input  twrpc_pkg::pos_t         target_move,
    input  twrpc_pkg::step_t        step_limit,
    input  twrpc_pkg::gain_t        gain,
    input  twrpc_pkg::pwr_t         power_limit,
    output twrpc_pkg::lane_result_t result
);
    import twrpc_pkg::*;

    // wheel state
    raw_t                    last_raw_reg, last_raw_next;
    pos_t                    odo_reg, odo_next;
    pos_t                    setpoint_reg, setpoint_next;
    pos_t                    target_reg, target_next;
    logic signed [RAW_W-1:0] delta_reg, delta_next;
    drv_t                    drive_hold_reg, drive_hold_next;

    // stage 1 / stage 2 registers
    pos_t                    p1_sp_reg, p1_odo_reg, p2_odo_reg;
    logic signed [RAW_W-1:0] p1_delta_reg, p2_delta_reg;
    logic [1:0]              p1_op_reg, p2_op_reg, op1;
    logic signed [PROD_W-1:0] p2_prod_reg;

    raw_t                    raw_delta;
    logic signed [ERR_W:0]   gap, step_s;
    pos_t                    ramped;
    logic signed [ERR_W-1:0] err;
    logic signed [PROD_W:0]  prod_full;
    logic signed [PROD_W-1:0] biased;
    logic signed [QUO_W-1:0] quo, lim_s;
    drv_t                    clamped;

    // ---- stage 1: odometry, ramp, target ----
    always_comb
    begin
        raw_delta = encoder - last_raw_reg;
        gap       = {{2{target_reg[POS_W-1]}}, target_reg}
                  - {{2{setpoint_reg[POS_W-1]}}, setpoint_reg};
        step_s    = $signed({{(ERR_W+1-STEP_W){1'b0}}, step_limit});
        if (gap > step_s)
            ramped = setpoint_reg + $signed({{(POS_W-STEP_W){1'b0}}, step_limit});
        else if (gap < -step_s)
            ramped = setpoint_reg - $signed({{(POS_W-STEP_W){1'b0}}, step_limit});
        else
            ramped = target_reg;

        last_raw_next = last_raw_reg;
        odo_next      = odo_reg;
        delta_next    = delta_reg;
        setpoint_next = setpoint_reg;
        target_next   = target_reg;
        if (ctrl.tick)
        begin
            if (ctrl.enc_ok)
            begin
                last_raw_next = encoder;
                delta_next    = $signed(raw_delta);
                odo_next      = odo_reg + {{(POS_W-RAW_W){raw_delta[RAW_W-1]}}, raw_delta};
            end
            if (ctrl.enabled)
                setpoint_next = ramped;
        end
        else
        begin
            target_next = target_reg + target_move;
        end

        priority if (!ctrl.tick)
            op1 = OP_HOLD;
        else if (ctrl.enabled)
            op1 = OP_DRIVE;
        else
            op1 = OP_ZERO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= '0;
            odo_reg      <= '0;
            setpoint_reg <= '0;
            target_reg   <= '0;
            delta_reg    <= '0;
        end
        else if (ctrl.load1)
        begin
            last_raw_reg <= last_raw_next;
            odo_reg      <= odo_next;
            setpoint_reg <= setpoint_next;
            target_reg   <= target_next;
            delta_reg    <= delta_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load1)
        begin
            p1_sp_reg    <= setpoint_next;
            p1_odo_reg   <= odo_next;
            p1_delta_reg <= delta_next;
            p1_op_reg    <= op1;
        end
    end

    // ---- stage 2: error times gain ----
    always_comb
    begin
        err       = {p1_sp_reg[POS_W-1], p1_sp_reg} - {p1_odo_reg[POS_W-1], p1_odo_reg};
        prod_full = err * $signed({1'b0, gain});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            p2_prod_reg  <= prod_full[PROD_W-1:0];
            p2_odo_reg   <= p1_odo_reg;
            p2_delta_reg <= p1_delta_reg;
            p2_op_reg    <= p1_op_reg;
        end
    end

    // ---- stage 3: truncate toward zero, clamp, pick drive ----
    always_comb
    begin
        // bias negatives so the arithmetic shift rounds toward zero
        biased = p2_prod_reg + (p2_prod_reg[PROD_W-1]
               ? $signed({{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}})
               : $signed({PROD_W{1'b0}}));
        quo    = biased[PROD_W-1:FRAC_W];
        lim_s  = $signed({{(QUO_W-PWR_W){1'b0}}, power_limit});
        if (quo > lim_s)
            clamped = lim_s[DRV_W-1:0];
        else if (quo < -lim_s)
            clamped = -lim_s[DRV_W-1:0];
        else
            clamped = quo[DRV_W-1:0];

        unique case (p2_op_reg)
            OP_DRIVE: drive_hold_next = clamped;
            OP_ZERO:  drive_hold_next = '0;
            OP_HOLD:  drive_hold_next = drive_hold_reg;
            default:  drive_hold_next = drive_hold_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drive_hold_reg <= '0;
        else if (ctrl.load3)
            drive_hold_reg <= drive_hold_next;
    end

    assign result.drive = drive_hold_next;
    assign result.delta = p2_delta_reg;
    assign result.odo   = p2_odo_reg;

endmodule

// ===== src/twrpc_merge.sv =====
module twrpc_merge (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  twrpc_pkg::lane_result_t left,
    input  twrpc_pkg::lane_result_t right,
    output logic                    free,
    twrpc_result_if.source          result
);
    import twrpc_pkg::*;

    logic         valid_reg, valid_next;
    lane_result_t left_reg, right_reg;

    // register empties or drains this cycle
    assign free = !valid_reg || result.ready;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg  <= left;
            right_reg <= right;
        end
    end

    assign result.valid             = valid_reg;
    assign result.left_drive        = left_reg.drive;
    assign result.right_drive       = right_reg.drive;
    assign result.left_count_delta  = left_reg.delta;
    assign result.right_count_delta = right_reg.delta;
    assign result.left_odometer     = left_reg.odo;
    assign result.right_odometer    = right_reg.odo;

endmodule

// ===== src/two_wheel_ramped_position_controller.sv =====
// Two-wheel position controller with ramped setpoints and proportional drive.
// Channels: cmd (sink) takes one item per handshake: a control tick with raw
// encoder counts, or an add-target item with relative moves. result (source)
// returns exactly one item per cmd item, in order: both drives, the last
// count deltas and both odometers. cfg (sink) writes one register per
// handshake; cfg.ready is always high. The user must see that writes are
// only made while idle; the block does not enforce this. Throughput: one
// item per cycle unless result stalls. The state loop (odometer add, setpoint
// ramp) closes in the first stage; the gain multiply has its own stage, and
// truncation/clamp feeds the merge register that joins the two wheel lanes.
// Reset: all wheel state, held drives and deltas clear; motors disabled,
// step limits zero, gain 3277 (about 0.05), power limit 200.
// When the receiver stalls, the merge register holds its item and stages
// behind it fill; cmd.ready drops only once all three stages are full.
module two_wheel_ramped_position_controller (
    input  logic            clk,
    input  logic            rst_n,
    twrpc_cmd_if.sink       cmd,
    twrpc_result_if.source  result,
    twrpc_cfg_if.sink       cfg
);
    import twrpc_pkg::*;

    // configuration registers
    logic  motors_enabled_reg;
    step_t left_step_limit_reg;
    step_t right_step_limit_reg;
    gain_t prop_gain_reg;
    pwr_t  power_limit_reg;

    // pipeline occupancy
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic merge_free;
    logic load1, load2, load3;
    logic rdy1, rdy2;

    lane_ctrl_t   ctrl;
    lane_result_t left_res, right_res;

    // ---- configuration port ----
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motors_enabled_reg   <= 1'b0;
            left_step_limit_reg  <= '0;
            right_step_limit_reg <= '0;
            prop_gain_reg        <= PROP_GAIN_RST;
            power_limit_reg      <= POWER_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MOTORS_ENABLED:   motors_enabled_reg   <= cfg.data[0];
                REG_LEFT_STEP_LIMIT:  left_step_limit_reg  <= cfg.data;
                REG_RIGHT_STEP_LIMIT: right_step_limit_reg <= cfg.data;
                REG_PROP_GAIN:        prop_gain_reg        <= cfg.data;
                REG_POWER_LIMIT:      power_limit_reg      <= cfg.data[PWR_W-1:0];
                default:              ;   // unknown index: ignored
            endcase
        end
    end

    // ---- stage advance: each stage moves when the one ahead has room ----
    assign load3 = v2_reg && merge_free;
    assign rdy2  = !v2_reg || load3;
    assign load2 = v1_reg && rdy2;
    assign rdy1  = !v1_reg || load2;
    assign load1 = cmd.valid && rdy1;

    assign cmd.ready = rdy1;

    always_comb
    begin
        priority if (load1)
            v1_next = 1'b1;
        else if (load2)
            v1_next = 1'b0;
        else
            v1_next = v1_reg;

        priority if (load2)
            v2_next = 1'b1;
        else if (load3)
            v2_next = 1'b0;
        else
            v2_next = v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_comb
    begin
        ctrl.load1   = load1;
        ctrl.tick    = (cmd.action == ACT_TICK);
        ctrl.enc_ok  = cmd.encoders_valid;
        ctrl.enabled = motors_enabled_reg;
        ctrl.load2   = load2;
        ctrl.load3   = load3;
    end

    // ---- wheel lanes ----
    twrpc_lane u_left (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .encoder     (cmd.left_encoder),
        .target_move (cmd.left_target_move),
        .step_limit  (left_step_limit_reg),
        .gain        (prop_gain_reg),
        .power_limit (power_limit_reg),
        .result      (left_res)
    );

    twrpc_lane u_right (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .encoder     (cmd.right_encoder),
        .target_move (cmd.right_target_move),
        .step_limit  (right_step_limit_reg),
        .gain        (prop_gain_reg),
        .power_limit (power_limit_reg),
        .result      (right_res)
    );

    // ---- merge: both lanes into one result item ----
    twrpc_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load3),
        .left   (left_res),
        .right  (right_res),
        .free   (merge_free),
        .result (result)
    );

`ifndef SYNTHESIS
    // an empty output register never blocks new items
    assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> cmd.ready)
        else $error("cmd stalled with empty output register");

    // a result appears only out of a filled second stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(v2_reg))
        else $error("result without a stage-2 item");

    // an item in stage 1 always moves into an empty stage 2
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !v2_reg) |=> v2_reg)
        else $error("stage-1 item lost");

    // accepted items are never dropped while the pipeline is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && result.valid && !result.ready) |=> (v1_reg && v2_reg))
        else $error("item dropped during stall");
`endif

endmodule

// ===== bench/two_wheel_ramped_position_controller_test.sv =====
`timescale 1ns / 100ps

module two_wheel_ramped_position_controller_test;
    import twrpc_pkg::*;

    // short full-speed run: largest deltas every tick, drive at its limit
    localparam int ODO_SWEEP_TICKS  = 130;
    // long receiver hold-off, well past the three pipeline stages
    localparam int LONG_HOLD_CYCLES = 48;
    // cycles to wait after the last result in case a stray one shows up
    localparam int DRAIN_CYCLES     = 8;

    // one command item, as offered on the cmd channel
    typedef struct packed {
        logic action;
        raw_t left_encoder;
        raw_t right_encoder;
        logic encoders_valid;
        pos_t left_target_move;
        pos_t right_target_move;
    } wheel_cmd_t;

    // one result item, as seen on the result channel
    typedef struct packed {
        drv_t                    left_drive;
        drv_t                    right_drive;
        logic signed [RAW_W-1:0] left_delta;
        logic signed [RAW_W-1:0] right_delta;
        pos_t                    left_odo;
        pos_t                    right_odo;
    } wheel_report_t;

    // Tracks the controller: register copy, wheel state, and the queue of
    // reports the block still owes us.
    class odometry_scoreboard;
        bit    enabled;
        step_t left_step;
        step_t right_step;
        gain_t gain;
        pwr_t  power_cap;

        raw_t                    left_raw, right_raw;
        pos_t                    left_odo, right_odo;
        pos_t                    left_setpoint, right_setpoint;
        pos_t                    left_target, right_target;
        logic signed [RAW_W-1:0] left_delta, right_delta;
        drv_t                    left_drv, right_drv;

        wheel_report_t expected_reports[$];
        int            mismatches;
        int            checked;

        function new();
            enabled        = 1'b0;
            left_step      = '0;
            right_step     = '0;
            gain           = PROP_GAIN_RST;
            power_cap      = POWER_LIMIT_RST;
            left_raw       = '0;
            right_raw      = '0;
            left_odo       = '0;
            right_odo      = '0;
            left_setpoint  = '0;
            right_setpoint = '0;
            left_target    = '0;
            right_target   = '0;
            left_delta     = '0;
            right_delta    = '0;
            left_drv       = '0;
            right_drv      = '0;
            mismatches     = 0;
            checked        = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_MOTORS_ENABLED:   enabled    = value[0];
                REG_LEFT_STEP_LIMIT:  left_step  = step_t'(value);
                REG_RIGHT_STEP_LIMIT: right_step = step_t'(value);
                REG_PROP_GAIN:        gain       = gain_t'(value);
                REG_POWER_LIMIT:      power_cap  = pwr_t'(value);
                default: ;
            endcase
        endfunction

        // distance is exact, so the setpoint never overshoots or wraps
        function pos_t ramp_setpoint(pos_t sp, pos_t tgt, step_t max_move);
            longint gap;
            longint lim;
            gap = longint'(tgt) - longint'(sp);
            lim = longint'(max_move);
            if (gap > lim)
                return pos_t'(longint'(sp) + lim);
            if (-gap > lim)
                return pos_t'(longint'(sp) - lim);
            return tgt;
        endfunction

        // exact error times gain, Q0.16 drop toward zero, then clamp
        function drv_t drive_command(pos_t sp, pos_t odo);
            longint err;
            longint prod;
            longint quo;
            longint lim;
            err  = longint'(sp) - longint'(odo);
            prod = err * longint'(gain);
            if (prod >= 0)
                quo = prod >>> FRAC_W;
            else
                quo = -((-prod) >>> FRAC_W);
            lim = longint'(power_cap);
            if (quo > lim)
                quo = lim;
            else if (quo < -lim)
                quo = -lim;
            return drv_t'(quo);
        endfunction

        function void note_command(wheel_cmd_t c);
            wheel_report_t r;
            if (c.action == ACT_ADD_TARGET) begin
                left_target  = left_target + c.left_target_move;
                right_target = right_target + c.right_target_move;
            end
            else begin
                if (c.encoders_valid) begin
                    left_delta  = c.left_encoder - left_raw;
                    right_delta = c.right_encoder - right_raw;
                    left_raw    = c.left_encoder;
                    right_raw   = c.right_encoder;
                    left_odo    = left_odo + left_delta;
                    right_odo   = right_odo + right_delta;
                end
                if (enabled) begin
                    left_setpoint  = ramp_setpoint(left_setpoint, left_target, left_step);
                    right_setpoint = ramp_setpoint(right_setpoint, right_target, right_step);
                    left_drv       = drive_command(left_setpoint, left_odo);
                    right_drv      = drive_command(right_setpoint, right_odo);
                end
                else begin
                    left_drv  = '0;
                    right_drv = '0;
                end
            end
            r.left_drive  = left_drv;
            r.right_drive = right_drv;
            r.left_delta  = left_delta;
            r.right_delta = right_delta;
            r.left_odo    = left_odo;
            r.right_odo   = right_odo;
            expected_reports.push_back(r);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(wheel_report_t got);
            wheel_report_t want;
            checked++;
            if (expected_reports.size() == 0) begin
                flag($sformatf("result %0d arrived with nothing outstanding", checked));
                return;
            end
            want = expected_reports.pop_front();
            if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
                got.left_delta !== want.left_delta || got.right_delta !== want.right_delta ||
                got.left_odo !== want.left_odo || got.right_odo !== want.right_odo)
                flag($sformatf({"result %0d: expected drv %0d/%0d dlt %0d/%0d odo %0d/%0d,",
                                " got drv %0d/%0d dlt %0d/%0d odo %0d/%0d"}, checked,
                               want.left_drive, want.right_drive, want.left_delta,
                               want.right_delta, want.left_odo, want.right_odo,
                               got.left_drive, got.right_drive, got.left_delta,
                               got.right_delta, got.left_odo, got.right_odo));
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    twrpc_cmd_if    cmd_bus();
    twrpc_result_if result_bus();
    twrpc_cfg_if    cfg_bus();

    two_wheel_ramped_position_controller uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always #4 clk = ~clk;

    odometry_scoreboard board;

    // knobs the stimulus sets; take_gaps and long_hold_pending steer the result sink
    bit send_gaps;
    bit take_gaps;
    bit long_hold_pending;

    // where the wheels really are, so valid ticks look like real motion
    raw_t left_wheel_raw;
    raw_t right_wheel_raw;

    // Offer one item, with an optional idle burst first; returns once the
    // item is accepted. valid is left high so back-to-back items never
    // see valid dropped and raised in the same step.
    task automatic send_command(input wheel_cmd_t c);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        cmd_bus.valid             <= 1'b1;
        cmd_bus.action            <= c.action;
        cmd_bus.left_encoder      <= c.left_encoder;
        cmd_bus.right_encoder     <= c.right_encoder;
        cmd_bus.encoders_valid    <= c.encoders_valid;
        cmd_bus.left_target_move  <= c.left_target_move;
        cmd_bus.right_target_move <= c.right_target_move;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        board.note_command(c);
    endtask

    task automatic tick(input raw_t l, input raw_t r, input bit ok);
        wheel_cmd_t c;
        c.action            = ACT_TICK;
        c.left_encoder      = l;
        c.right_encoder     = r;
        c.encoders_valid    = ok;
        c.left_target_move  = pos_t'($urandom);
        c.right_target_move = pos_t'($urandom);
        if (ok) begin
            left_wheel_raw  = l;
            right_wheel_raw = r;
        end
        send_command(c);
    endtask

    task automatic add_targets(input pos_t l, input pos_t r);
        wheel_cmd_t c;
        c.action            = ACT_ADD_TARGET;
        c.left_encoder      = raw_t'($urandom);
        c.right_encoder     = raw_t'($urandom);
        c.encoders_valid    = 1'($urandom);
        c.left_target_move  = l;
        c.right_target_move = r;
        send_command(c);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        board.set_register(idx, value);
    endtask

    // Registers only change with the pipe empty: every item yields a
    // result, so an empty expectation queue means the block is idle.
    task automatic apply_settings(input bit en, input step_t ls, input step_t rs,
                                  input gain_t g, input logic [CFG_DATA_W-1:0] plim);
        cmd_bus.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        // junk in the upper bits of the enable, and a write to a hole
        // in the register map; both must be ignored
        write_register(REG_MOTORS_ENABLED, {15'($urandom), en});
        write_register(REG_LEFT_STEP_LIMIT, ls);
        write_register(REG_RIGHT_STEP_LIMIT, rs);
        write_register(REG_PROP_GAIN, g);
        write_register(REG_POWER_LIMIT, plim);
        write_register(REG_POWER_LIMIT + 3'($urandom_range(1, 3)), 16'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly plausible motion: small encoder steps and modest target
    // moves, with the odd jump, bad read and extreme move mixed in.
    function automatic wheel_cmd_t random_command();
        wheel_cmd_t c;
        c.left_target_move  = pos_t'($urandom);
        c.right_target_move = pos_t'($urandom);
        c.left_encoder      = raw_t'($urandom);
        c.right_encoder     = raw_t'($urandom);
        if ($urandom_range(0, 99) < 20) begin
            c.action         = ACT_ADD_TARGET;
            c.encoders_valid = 1'($urandom);
            case ($urandom_range(0, 15))
                0: begin
                    c.left_target_move  = 32'h8000_0000;
                    c.right_target_move = 32'h7fff_ffff;
                end
                1, 2: ;  // keep the full-range random moves
                default: begin
                    c.left_target_move  = pos_t'($urandom_range(0, 20000) - 10000);
                    c.right_target_move = pos_t'($urandom_range(0, 20000) - 10000);
                end
            endcase
        end
        else begin
            c.action         = ACT_TICK;
            c.encoders_valid = ($urandom_range(0, 9) != 0);
            if (c.encoders_valid) begin
                if ($urandom_range(0, 11) == 0) begin
                    left_wheel_raw  = c.left_encoder;
                    right_wheel_raw = c.right_encoder;
                end
                else begin
                    left_wheel_raw  = left_wheel_raw + raw_t'($urandom_range(0, 600) - 300);
                    right_wheel_raw = right_wheel_raw + raw_t'($urandom_range(0, 600) - 300);
                end
                c.left_encoder  = left_wheel_raw;
                c.right_encoder = right_wheel_raw;
            end
        end
        return c;
    endfunction

    task automatic run_random(input int count);
        repeat (count)
            send_command(random_command());
    endtask

    // Result sink: checks every accepted item and throttles ready with
    // random stall bursts, plus one long hold-off on request.
    initial begin : result_sink
        int            stall_left;
        wheel_report_t got;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready) begin
                got.left_drive  = result_bus.left_drive;
                got.right_drive = result_bus.right_drive;
                got.left_delta  = result_bus.left_count_delta;
                got.right_delta = result_bus.right_count_delta;
                got.left_odo    = result_bus.left_odometer;
                got.right_odo   = result_bus.right_odometer;
                board.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                stall_left = LONG_HOLD_CYCLES - 1;
                result_bus.ready <= 1'b0;
            end
            else if (take_gaps && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 10);
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    initial begin : stimulus
        bit         left_up;
        bit         right_up;
        wheel_cmd_t c;

        board = new();
        send_gaps         = 1'b0;
        take_gaps         = 1'b0;
        long_hold_pending = 1'b0;
        left_wheel_raw    = '0;
        right_wheel_raw   = '0;

        rst_n                     <= 1'b0;
        cmd_bus.valid             <= 1'b0;
        cmd_bus.action            <= ACT_TICK;
        cmd_bus.left_encoder      <= '0;
        cmd_bus.right_encoder     <= '0;
        cmd_bus.encoders_valid    <= 1'b0;
        cmd_bus.left_target_move  <= '0;
        cmd_bus.right_target_move <= '0;
        cfg_bus.valid             <= 1'b0;
        cfg_bus.index             <= REG_MOTORS_ENABLED;
        cfg_bus.data              <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset registers, motors off ---
        tick(16'h0000, 16'h0000, 1'b1);
        tick(16'h7fff, 16'h8000, 1'b1);         // largest steps both ways
        tick(16'hffff, 16'h0000, 1'b1);         // raw count wraps
        tick(16'h1234, 16'hedcb, 1'b0);         // bad read: odometry kept
        add_targets(32'h7fff_ffff, 32'h8000_0000);
        add_targets(32'h0000_0001, 32'hffff_ffff);  // both targets wrap

        // full-scale gain, step and power: drive saturates on huge errors
        apply_settings(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        tick(16'h0001, 16'hfffe, 1'b1);
        tick(16'h8001, 16'h7fff, 1'b1);
        tick(16'h8001, 16'h7fff, 1'b0);
        add_targets(32'h8000_0000, 32'h7fff_ffff);
        tick(16'h0000, 16'hffff, 1'b1);
        tick(16'h0000, 16'hffff, 1'b1);

        // zero step, gain and power: setpoints frozen, drive zero
        apply_settings(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        tick(16'h5555, 16'haaaa, 1'b1);
        add_targets(32'h0000_4000, 32'hffff_c000);
        tick(16'haaaa, 16'h5555, 1'b1);

        // smallest nonzero power limit, unequal wheel steps
        apply_settings(1'b1, 16'h0001, 16'h8000, 16'h8000, 16'h0001);
        tick(16'haaab, 16'h5554, 1'b1);
        tick(16'haaac, 16'h5553, 1'b1);

        // disabling clears the held drives, setpoints stay put
        apply_settings(1'b0, 16'h00ff, 16'hff00, 16'h7fff, 16'h4000);
        tick(16'haaad, 16'h5552, 1'b1);
        add_targets(32'h0001_0000, 32'hfffe_0000);
        tick(16'h0bad, 16'hf00d, 1'b0);

        // --- random phases ---
        send_gaps = 1'b1;
        take_gaps = 1'b1;
        apply_settings(1'b1, 16'd500, 16'd800, PROP_GAIN_RST, 16'd200);
        run_random(400);

        // long hold-off with the sender pushing flat out: the pipe fills
        // and cmd.ready must drop
        apply_settings(1'b1, 16'h0000, 16'hffff, 16'hffff, 16'h7fff);
        send_gaps = 1'b0;
        long_hold_pending = 1'b1;
        run_random(80);
        send_gaps = 1'b1;
        run_random(170);

        apply_settings(1'b0, 16'd1234, 16'd4321, 16'd20000, 16'd1000);
        run_random(250);

        apply_settings(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_random(250);

        apply_settings(1'b1, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
        run_random(200);

        // full speed: each wheel runs away from zero in the direction it
        // already leans, with the largest delta every tick
        send_gaps = 1'b0;
        take_gaps = 1'b0;
        apply_settings(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'h7fff);
        left_up  = !board.left_odo[POS_W-1];
        right_up = !board.right_odo[POS_W-1];
        for (int n = 0; n < ODO_SWEEP_TICKS; n++) begin
            left_wheel_raw  = left_wheel_raw + (left_up ? 16'h7fff : 16'h8001);
            right_wheel_raw = right_wheel_raw + (right_up ? 16'h7fff : 16'h8001);
            c.action            = ACT_TICK;
            c.left_encoder      = left_wheel_raw;
            c.right_encoder     = right_wheel_raw;
            c.encoders_valid    = 1'b1;
            c.left_target_move  = pos_t'($urandom);
            c.right_target_move = pos_t'($urandom);
            send_command(c);
        end

        // closing stretch runs without idling on either side
        apply_settings(1'b1, 16'd3000, 16'd3000, 16'd40000, 16'd15000);
        run_random(300);

        cmd_bus.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/twrpc_pkg.sv
src/twrpc_if.sv
src/twrpc_lane.sv
src/twrpc_merge.sv
src/two_wheel_ramped_position_controller.sv
bench/two_wheel_ramped_position_controller_test.sv
